// ----- rtl/efdp_pkg.sv -----
package efdp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int ANGLE_W = 4;
    localparam int DIST_W  = 8;
    localparam int ACC_W   = 14;
    localparam int DIGIT_W = 4;

    // Character codes and reset values
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO   = 8'd48;
    localparam logic [BYTE_W-1:0] DIGIT_NINE   = 8'd57;
    localparam logic [DIST_W-1:0] LIMIT_RESET  = 8'd150;

    // Input selector codes (s_tuser)
    localparam logic CMD_PARSE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Result kind codes (m_tuser)
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Parser position: hunting, four distance digits, angle digit, closing newline
    typedef enum logic [2:0] {
        FP_HUNT,
        FP_DIG1,
        FP_DIG2,
        FP_DIG3,
        FP_DIG4,
        FP_ANGLE,
        FP_CLOSE
    } frame_pos_t;

    // Operation handed from the parser to the table side
    typedef struct packed {
        logic               kind;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  distance;
    } op_t;

endpackage

// ----- rtl/efdp_front.sv -----
module efdp_front #(
    parameter int TABLE_DEPTH = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [efdp_pkg::DIST_W-1:0]   cfg_data,
    // incoming item
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [efdp_pkg::BYTE_W-1:0]   in_byte,
    input  logic [efdp_pkg::ANGLE_W-1:0]  in_read_angle,
    // operation to the queue
    output logic                          op_valid,
    input  logic                          op_ready,
    output efdp_pkg::op_t                 op
);
    import efdp_pkg::*;

    logic [DIST_W-1:0]  limit_reg;
    frame_pos_t         pos_reg, pos_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [DIGIT_W-1:0] ang_reg, ang_next;

    logic               accept;
    logic               is_digit;
    logic               is_newline;
    logic [DIGIT_W-1:0] digit;
    logic [BYTE_W-1:0]  digit_full;
    logic [ACC_W-1:0]   acc_step;
    logic [DIST_W-1:0]  clamped;

    assign cfg_ready = 1'b1;
    assign in_ready  = op_ready;
    assign accept    = in_valid && in_ready;

    // Byte classification and decimal accumulate (acc * 10 + digit)
    assign is_newline = (in_byte == NEWLINE_CHAR);
    assign is_digit   = (in_byte >= DIGIT_ZERO) && (in_byte <= DIGIT_NINE);
    assign digit_full = in_byte - DIGIT_ZERO;
    assign digit      = digit_full[DIGIT_W-1:0];
    assign acc_step   = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0}
                      + {{(ACC_W-DIGIT_W){1'b0}}, digit};

    // Clamp to the configured limit
    assign clamped = (acc_reg > {{(ACC_W-DIST_W){1'b0}}, limit_reg})
                   ? limit_reg : acc_reg[DIST_W-1:0];

    // Limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= FP_HUNT;
            acc_reg <= '0;
            ang_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            ang_reg <= ang_next;
        end
    end

    // Next state and operation issue
    always_comb
    begin
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        ang_next    = ang_reg;
        op_valid    = 1'b0;
        op.kind     = KIND_REPORT;
        op.angle    = ang_reg;
        op.distance = clamped;

        if (accept && in_cmd == CMD_READ)
        begin
            op_valid    = 1'b1;
            op.kind     = KIND_READ;
            op.angle    = in_read_angle;
            op.distance = '0;
        end
        else if (accept)
        begin
            case (pos_reg)
                FP_HUNT:
                begin
                    if (is_newline)
                    begin
                        pos_next = FP_DIG1;
                        acc_next = '0;
                    end
                end
                FP_DIG1, FP_DIG2, FP_DIG3, FP_DIG4:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_step;
                        pos_next = frame_pos_t'(pos_reg + 3'd1);
                    end
                    else if (is_newline)
                    begin
                        pos_next = FP_DIG1;
                        acc_next = '0;
                    end
                    else
                    begin
                        pos_next = FP_HUNT;
                    end
                end
                FP_ANGLE:
                begin
                    if (is_digit)
                    begin
                        ang_next = digit;
                        pos_next = FP_CLOSE;
                    end
                    else if (is_newline)
                    begin
                        pos_next = FP_DIG1;
                        acc_next = '0;
                    end
                    else
                    begin
                        pos_next = FP_HUNT;
                    end
                end
                FP_CLOSE:
                begin
                    if (is_newline)
                    begin
                        // frame complete; angles past the table are dropped
                        op_valid = (int'(ang_reg) < TABLE_DEPTH);
                        pos_next = FP_DIG1;
                        acc_next = '0;
                    end
                    else
                    begin
                        pos_next = FP_HUNT;
                    end
                end
                default:
                begin
                    pos_next = FP_HUNT;
                end
            endcase
        end
    end

    // Checks
    a_report_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op.kind == KIND_REPORT |-> op.distance <= limit_reg)
        else $error("report distance above limit");

    a_read_keeps_parser: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_cmd == CMD_READ |=> $stable(pos_reg) && $stable(acc_reg))
        else $error("read command disturbed the parser");

endmodule

// ----- rtl/efdp_fifo.sv -----
module efdp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  efdp_pkg::op_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output efdp_pkg::op_t rd_data
);
    import efdp_pkg::*;

    // Two entries let both sides stall on their own at full rate
    op_t        mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/efdp_back.sv -----
module efdp_back #(
    parameter int TABLE_DEPTH = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // operation from the queue
    input  logic                          op_valid,
    output logic                          op_ready,
    input  efdp_pkg::op_t                 op,
    // result
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          res_kind,
    output logic [efdp_pkg::ANGLE_W-1:0]  res_angle,
    output logic [efdp_pkg::DIST_W-1:0]   res_distance
);
    import efdp_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [DIST_W-1:0]  table_reg [TABLE_DEPTH];
    logic               valid_reg;
    logic               kind_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [DIST_W-1:0]  dist_reg;

    logic               pop;
    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic [DIST_W-1:0]  read_dist;

    assign op_ready  = !valid_reg || res_ready;
    assign pop       = op_valid && op_ready;
    assign in_range  = (int'(op.angle) < TABLE_DEPTH);
    assign idx       = op.angle[IDX_W-1:0];
    assign read_dist = in_range ? table_reg[idx] : '0;

    // Distance table, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (pop && op.kind == KIND_REPORT && in_range)
        begin
            table_reg[idx] <= op.distance;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (op_ready)
        begin
            valid_reg <= op_valid;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= op.kind;
            angle_reg <= op.angle;
            dist_reg  <= (op.kind == KIND_READ) ? read_dist : op.distance;
        end
    end

    assign res_valid    = valid_reg;
    assign res_kind     = kind_reg;
    assign res_angle    = angle_reg;
    assign res_distance = dist_reg;

    // Checks
    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> res_valid)
        else $error("popped operation produced no result");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pop && op.kind == KIND_REPORT && in_range
        |=> table_reg[$past(idx)] == $past(op.distance))
        else $error("table write lost");

    a_read_past_table: assert property (@(posedge clk) disable iff (!rst_n)
        pop && op.kind == KIND_READ && !in_range |=> res_distance == '0)
        else $error("read beyond table not zero");

    a_kind_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> res_kind == $past(op.kind) && res_angle == $past(op.angle))
        else $error("result kind or angle mismatch");

endmodule

// ----- rtl/echo_distance_frame_parser.sv -----
// The queue takes the item at the accepting edge; the back end then moves it from the queue
// into the output register when that register is free, and holds it there until it is taken.
// Throughput: one item per cycle while the queue has room; parser, queue and table each take
// one item a cycle. A byte that ends no frame, or ends one past the table, gives no result.
// Reset (rst_n low, asynchronous): parser hunts for a newline, limit is 150, table is zero.
// The table clears at once in flip-flops; the block accepts items right after reset.
module echo_distance_frame_parser #(
    parameter int TABLE_DEPTH = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: distance limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [11:8] read_angle, [15:12] zero
    input  logic        s_tuser,   // cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] angle, [11:4] distance, [15:12] zero
    output logic        m_tuser    // kind
);
    import efdp_pkg::*;

    logic               f_valid;
    logic               f_ready;
    op_t                f_op;
    logic               q_valid;
    logic               q_ready;
    op_t                q_op;
    logic [ANGLE_W-1:0] res_angle;
    logic [DIST_W-1:0]  res_distance;

    efdp_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (s_tuser),
        .in_byte       (s_tdata[7:0]),
        .in_read_angle (s_tdata[11:8]),
        .op_valid      (f_valid),
        .op_ready      (f_ready),
        .op            (f_op)
    );

    efdp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_op),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_op)
    );

    efdp_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (q_valid),
        .op_ready     (q_ready),
        .op           (q_op),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_kind     (m_tuser),
        .res_angle    (res_angle),
        .res_distance (res_distance)
    );

    assign m_tdata = {4'b0000, res_distance, res_angle};

endmodule

// ----- tb/distance_frame_checker.sv -----
`timescale 1ns / 1ps

// Watches the config, input and result channels, predicts every result from
// the accepted items and compares each result against the oldest prediction.
module distance_frame_checker #(
    parameter int TABLE_DEPTH = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [11:8] read_angle, [15:12] zero
    input  logic        s_tuser,   // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [3:0] angle, [11:4] distance, [15:12] zero
    input  logic        m_tuser,   // kind
    output int          fail_count,
    output int          pending,
    output int          report_count,
    output int          read_count
);
    import efdp_pkg::*;

    // Predicted results, oldest first
    op_t                expected_q[$];

    // Parser state and distance table as the block should hold them
    frame_pos_t         pos_q;
    logic [ACC_W-1:0]   acc_q;
    logic [DIGIT_W-1:0] angle_q;
    logic [DIST_W-1:0]  limit_q;
    logic [DIST_W-1:0]  dist_mem [TABLE_DEPTH];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result check failed: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void open_frame();
        pos_q = FP_DIG1;
        acc_q = '0;
    endfunction

    // Advance the parser by one item; queue a result if the item causes one
    function automatic void predict_item(input logic cmd, input logic [7:0] b,
                                         input logic [3:0] ra);
        op_t              res;
        logic [ACC_W-1:0] clamped;
        logic             digit;
        digit = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
        if (cmd == CMD_READ)
        begin
            res.kind     = KIND_READ;
            res.angle    = ra;
            res.distance = (ra < TABLE_DEPTH) ? dist_mem[ra] : '0;
            expected_q.push_back(res);
            return;
        end
        case (pos_q)
            FP_HUNT:
            begin
                if (b == NEWLINE_CHAR)
                    open_frame();
            end
            FP_DIG1, FP_DIG2, FP_DIG3, FP_DIG4:
            begin
                if (digit)
                begin
                    acc_q = ACC_W'(acc_q * 10 + (b - DIGIT_ZERO));
                    pos_q = frame_pos_t'(pos_q + 1);
                end
                else if (b == NEWLINE_CHAR)
                    open_frame();
                else
                    pos_q = FP_HUNT;
            end
            FP_ANGLE:
            begin
                if (digit)
                begin
                    angle_q = DIGIT_W'(b - DIGIT_ZERO);
                    pos_q   = FP_CLOSE;
                end
                else if (b == NEWLINE_CHAR)
                    open_frame();
                else
                    pos_q = FP_HUNT;
            end
            FP_CLOSE:
            begin
                if (b == NEWLINE_CHAR)
                begin
                    clamped = (acc_q > ACC_W'(limit_q)) ? ACC_W'(limit_q) : acc_q;
                    // angle past the table: frame dropped silently
                    if (angle_q < TABLE_DEPTH)
                    begin
                        dist_mem[angle_q] = DIST_W'(clamped);
                        res.kind     = KIND_REPORT;
                        res.angle    = angle_q;
                        res.distance = DIST_W'(clamped);
                        expected_q.push_back(res);
                    end
                    open_frame();
                end
                else
                    pos_q = FP_HUNT;    // extra byte before the closing newline
            end
            default:
                pos_q = FP_HUNT;
        endcase
    endfunction

    // Track state, match results against predictions
    always @(posedge clk or negedge rst_n)
    begin
        op_t want;
        if (!rst_n)
        begin
            pos_q   = FP_HUNT;
            acc_q   = '0;
            angle_q = '0;
            limit_q = LIMIT_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++)
                dist_mem[i] = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_q = cfg_data;

            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d angle %0d dist %0d",
                                              m_tuser, m_tdata[3:0], m_tdata[11:4]));
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  m_tuser, want.kind));
                    if (m_tdata[3:0] !== want.angle)
                        report_mismatch($sformatf("angle %0d, expected %0d",
                                                  m_tdata[3:0], want.angle));
                    if (m_tdata[11:4] !== want.distance)
                        report_mismatch($sformatf("distance %0d, expected %0d (angle %0d)",
                                                  m_tdata[11:4], want.distance, want.angle));
                    if (want.kind == KIND_READ)
                        read_count++;
                    else
                        report_count++;
                end
            end

            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata[7:0], s_tdata[11:8]);

            pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import efdp_pkg::*;

    localparam int DEPTH            = 10;
    localparam int CLK_PERIOD       = 12;
    localparam int RUN_LIMIT_CYCLES = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;   // [7:0] rx_byte, [11:8] read_angle, [15:12] zero
    logic        s_tuser   = 1'b0;    // cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [3:0] angle, [11:4] distance, [15:12] zero
    logic        m_tuser;             // kind

    int          fail_count;
    int          pending;
    int          report_count;
    int          read_count;

    // Pacing controls for the sender and the receiver, item counts and the current limit
    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;
    int          hold_req     = 0;
    int          sent_items   = 0;
    int          limit_writes = 0;
    logic [7:0]  cur_limit    = LIMIT_RESET;

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    echo_distance_frame_parser #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    distance_frame_checker #(
        .TABLE_DEPTH (DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .report_count (report_count),
        .read_count   (read_count)
    );

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [7:0] pick_nondigit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= DIGIT_ZERO && b <= DIGIT_NINE);
        return b;
    endfunction

    // Distances spread over the full range, small values and the clamp edge
    function automatic int pick_distance();
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 9999);
            1:       v = $urandom_range(0, 300);
            2:       v = int'(cur_limit) + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(0, 99);
        endcase
        return (v < 0) ? 0 : v;
    endfunction

    // One item on the input stream, after a drawn gap
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic [3:0] ra);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, ra, b};
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_PARSE, b, 4'($urandom_range(0, 15)));
    endtask

    task automatic send_read(input logic [3:0] ra);
        send_item(CMD_READ, 8'($urandom_range(0, 255)), ra);
    endtask

    task automatic send_digit();
        send_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Four distance digits, angle digit, closing newline
    task automatic send_frame(input int value, input int ang);
        int div;
        div = 1000;
        for (int k = 0; k < 4; k++)
        begin
            send_byte(DIGIT_ZERO + 8'((value / div) % 10));
            div = div / 10;
        end
        send_byte(DIGIT_ZERO + 8'(ang));
        send_byte(NEWLINE_CHAR);
    endtask

    // Stop offering items until every predicted result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] lim);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = lim;
        limit_writes++;
    endtask

    // Mostly well-formed frames with random content, plus reads and damage
    task automatic run_traffic(input int n);
        int stop;
        int r;
        int ndig;
        logic [7:0] b;
        stop = sent_items + n;
        send_byte(NEWLINE_CHAR);
        while (sent_items < stop)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                send_frame(pick_distance(), $urandom_range(0, 9));
            else if (r < 75)
                send_read(4'($urandom_range(0, 15)));
            else if (r < 85)
            begin
                // frame broken at a digit or at the angle position
                ndig = $urandom_range(0, 4);
                for (int k = 0; k < ndig; k++)
                    send_digit();
                send_byte($urandom_range(0, 1) ? NEWLINE_CHAR : pick_nondigit());
                send_byte(NEWLINE_CHAR);
            end
            else if (r < 92)
            begin
                // stray byte where the closing newline belongs
                for (int k = 0; k < 5; k++)
                    send_digit();
                do
                    b = 8'($urandom_range(0, 255));
                while (b == NEWLINE_CHAR);
                send_byte(b);
                send_byte(NEWLINE_CHAR);
            end
            else
            begin
                ndig = $urandom_range(1, 6);
                for (int k = 0; k < ndig; k++)
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(NEWLINE_CHAR);
            end
        end
    endtask

    // Result side: drawn stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            stall = draw_wait(rx_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid && hold_req == 0);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [7:0] lim;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: read past the table, clamp at the reset limit, zero frame
        send_read(4'd15);
        send_byte(NEWLINE_CHAR);
        repeat (5) send_byte("9");
        send_byte(NEWLINE_CHAR);
        repeat (5) send_byte("0");
        send_byte(NEWLINE_CHAR);
        // newline inside the digits reopens, other non-digit drops to hunting
        send_byte("1");
        send_byte(NEWLINE_CHAR);
        send_byte("3");
        send_byte(":");
        send_byte(NEWLINE_CHAR);
        // extra byte after the angle digit drops the frame for angle 3
        send_byte("0");
        send_byte("2");
        send_byte("5");
        send_byte("5");
        send_byte("3");
        send_byte(8'hFF);
        send_read(4'd9);
        send_read(4'd3);
        send_read(4'd0);

        // Random phases, each under its own distance limit
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       lim = 8'd255;
                1:       lim = 8'd0;
                3:       lim = 8'd1;
                5:       lim = LIMIT_RESET;
                default: lim = 8'($urandom_range(0, 255));
            endcase
            write_limit(lim);
            if (p == 4)
            begin
                // receiver holds off while reads pile up in the block
                tx_calm  = 1'b1;
                hold_req = 300;
                repeat (60) send_read(4'($urandom_range(0, 15)));
            end
            run_traffic(220);
        end

        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d items under %0d distance limit settings",
                 sent_items, limit_writes + 1);
        $display("checked %0d stored-frame reports and %0d table reads",
                 report_count, read_count);
        if (fail_count == 0 && pending == 0)
            $display("[echo_distance_frame_parser] OK");
        else
            $display("[echo_distance_frame_parser] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("timeout: %0d results still outstanding", pending);
        $display("[echo_distance_frame_parser] ERROR");
        $finish;
    end

endmodule
